// File: sv/assert_macros.svh
// assertion macros used by the fm register clock converter back end
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define FMRC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked at every edge, reset included
`define FMRC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: sv/fmrc_pkg.sv
`timescale 1ns / 1ps
// types, constants and helper functions of the fm register clock converter
// no dependencies
package fmrc_pkg;

  // item classes decided by the front end
  typedef enum logic [2:0] {
    OP_PASS,
    OP_MODE,
    OP_CSM,
    OP_FNUM_HI,
    OP_FNUM_LO,
    OP_TONE,
    OP_NOISE,
    OP_ENV
  } op_e;

  // back end sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_WRITE,
    S_RD_RAW,
    S_RD_CONV,
    S_M1,
    S_M2,
    S_M3,
    S_M4,
    S_FIN,
    S_EMIT
  } st_e;

  // classified item held in the queue
  typedef struct packed {
    op_e        op;
    logic       bank;
    logic [7:0] addr;
    logic [7:0] data;
  } qent_t;

  // one translated register write
  typedef struct packed {
    logic       bank;
    logic [7:0] addr;
    logic [7:0] data;
  } wr_t;

  // configuration register indexes
  localparam logic CFG_STD_DIV = 1'b0;
  localparam logic CFG_EXT_DIV = 1'b1;
  localparam logic [2:0] DIV_RESET = 3'd3;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned FNUM_DEPTH = 32;
  localparam int unsigned PSG_DEPTH = 16;

  // special addresses and data codes
  localparam logic [7:0] ADDR_MODE    = 8'h27;
  localparam logic [7:0] ADDR_KEYON   = 8'h28;
  localparam logic [7:0] ADDR_CSM     = 8'hff;
  localparam logic [7:0] ADDR_NOISE   = 8'h06;
  localparam logic [7:0] ADDR_ENV_LO  = 8'h0b;
  localparam logic [7:0] ADDR_ENV_HI  = 8'h0c;
  localparam logic [7:0] ADDR_FN_MIN  = 8'ha0;
  localparam logic [7:0] ADDR_FN_MAX  = 8'hae;
  localparam logic [7:0] KEYON_MASK   = 8'hf3;
  localparam logic [7:0] KEYON_SET    = 8'h04;
  localparam logic [7:0] CSM_KEY_OFF  = 8'h02;
  localparam logic [7:0] CSM_KEY_ON   = 8'hf2;
  localparam logic [7:0] MODE_ON      = 8'h40;
  localparam logic [7:0] FN_BLK_MASK  = 8'h38;
  localparam logic [7:0] FNUM_RESET   = 8'h00;
  localparam logic [7:0] PSG_RESET    = 8'hff;

  // psg shadow layout
  localparam logic [3:0] PSG_ENV_LO   = 4'd6;
  localparam logic [3:0] PSG_ENV_HI   = 4'd7;
  localparam logic [3:0] PSG_ENV_OFS  = 4'd5;
  localparam logic [3:0] PSG_CONV_OFS = 4'd8;

  // saturation limits
  localparam logic [15:0] TONE_MAX    = 16'd4095;
  localparam logic [15:0] NOISE_MAX   = 16'd31;
  localparam logic [17:0] ENV_SAT_LIM = 18'd80530;
  localparam logic [15:0] ENV_SAT_VAL = 16'hffff;

  // exact ratio constants: x*625/768 and x*576/625
  localparam logic [28:0] PSG_MUL     = 29'd625;
  localparam logic [35:0] RECIP_3     = 36'd174763;   // ceil(2^19 / 3)
  localparam logic [21:0] FN_MUL      = 22'd576;
  localparam logic [44:0] RECIP_625   = 45'd6871948;  // ceil(2^32 / 625)

  // envelope offset for a prescaler divider
  function automatic logic [1:0] eg_off(input logic [2:0] div);
    logic [1:0] p;
    unique case (div)
      3'd6:    p = 2'd2;
      3'd2:    p = 2'd0;
      default: p = 2'd1;
    endcase
    return p;
  endfunction

  // floor(2^16 / div), zero divider taken as one
  function automatic logic [16:0] recip_div(input logic [2:0] div);
    logic [16:0] r;
    unique case (div)
      3'd0: r = 17'd65536;
      3'd1: r = 17'd65536;
      3'd2: r = 17'd32768;
      3'd3: r = 17'd21845;
      3'd4: r = 17'd16384;
      3'd5: r = 17'd13107;
      3'd6: r = 17'd10922;
      3'd7: r = 17'd9362;
    endcase
    return r;
  endfunction

endpackage

// File: sv/fmrc_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces of the fm register clock converter
// no dependencies
interface fmrc_in_if;
  logic       valid;
  logic       ready;
  logic       bank;
  logic [7:0] reg_address;
  logic [7:0] reg_data;

  modport source (output valid, bank, reg_address, reg_data, input ready);
  modport sink (input valid, bank, reg_address, reg_data, output ready);
endinterface

interface fmrc_out_if;
  logic       valid;
  logic       ready;
  logic       out_bank;
  logic [7:0] out_address;
  logic [7:0] out_data;
  logic       last;

  modport source (output valid, out_bank, out_address, out_data, last, input ready);
  modport sink (input valid, out_bank, out_address, out_data, last, output ready);
endinterface

// File: sv/fm_register_clock_converter.sv
`timescale 1ns / 1ps
// Translates sound-chip register writes for a target chip on another clock.
// Input channel in_i carries (bank, reg_address, reg_data); output channel out_o
// carries zero to two translated writes per item, last marking the final one.
// Configuration: cfg_we_i writes cfg_data_i into divider register cfg_idx_i
// (0 bank A prescaler, 1 bank B prescaler), both reset to 3.
// Items enter a two-entry queue as soon as it has room, so the input side keeps
// moving while a result waits in the output register.
// The back end sequencer handles one item at a time: a plain write goes from
// S_WRITE to S_EMIT; psg tone and envelope items pass the shadow reads and the
// multiply states, noise items the multiply states, and a lower f-number byte
// the shadow reads, the whole multiply chain and S_FIN. An upper f-number byte,
// or a CSM trigger with CSM off, gives no result.
// Reset clears the queue, the CSM flag and the valid bits of the shadow stores,
// which then read as their cleared values; no clearing pass is needed.
// When out_o.ready is low the output register holds; the back end stops and the
// queue fills, after which in_i.ready drops.
// depends on fmrc_pkg, fmrc_if, fmrc_front, fmrc_queue and fmrc_back
module fm_register_clock_converter import fmrc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [2:0] cfg_data_i,
  fmrc_in_if.sink    in_i,
  fmrc_out_if.source out_o
);

  logic [2:0] std_div_q, ext_div_q;
  logic       push, full, pop, q_valid;
  qent_t      ent_in, ent_out;

  // divider registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      std_div_q <= DIV_RESET;
      ext_div_q <= DIV_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STD_DIV: std_div_q <= cfg_data_i;
        CFG_EXT_DIV: ext_div_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fmrc_front u_front (
    .in_i      (in_i),
    .std_div_i (std_div_q),
    .ext_div_i (ext_div_q),
    .full_i    (full),
    .push_o    (push),
    .ent_o     (ent_in)
  );

  fmrc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ent_i   (ent_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .ent_o   (ent_out)
  );

  fmrc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .std_div_i (std_div_q),
    .ext_div_i (ext_div_q),
    .q_valid_i (q_valid),
    .q_ent_i   (ent_out),
    .q_pop_o   (pop),
    .out_o     (out_o)
  );

endmodule

// File: sv/fmrc_front.sv
`timescale 1ns / 1ps
// front end: takes input items, classifies them and applies envelope-rate fixes
// depends on fmrc_pkg and fmrc_if
module fmrc_front import fmrc_pkg::*; (
  fmrc_in_if.sink    in_i,
  input  logic [2:0] std_div_i,
  input  logic [2:0] ext_div_i,
  input  logic       full_i,
  output logic       push_o,
  output qent_t      ent_o
);

  // reduce envelope rate fields by the prescaler offset
  function automatic logic [7:0] eg_fix(input logic [7:0] a, input logic [7:0] d,
                                        input logic [1:0] p);
    logic [7:0] r;
    r = d;
    if (a >= 8'h50 && a <= 8'h7f) begin
      if (d[4:0] != 5'h1f && d[4:0] >= {3'b0, p}) begin
        r[4:0] = d[4:0] - {3'b0, p};
      end
    end else if (a >= 8'h80 && a <= 8'h8f) begin
      if (d[3:0] != 4'hf && d[3:0] >= {2'b0, p}) begin
        r[3:0] = d[3:0] - {2'b0, p};
      end
    end
    return r;
  endfunction

  logic [1:0] p;
  logic [7:0] dfix;
  logic       fn_range;

  assign p        = in_i.bank ? eg_off(ext_div_i) : eg_off(std_div_i);
  assign dfix     = eg_fix(in_i.reg_address, in_i.reg_data, p);
  assign fn_range = in_i.reg_address >= ADDR_FN_MIN && in_i.reg_address <= ADDR_FN_MAX &&
                    in_i.reg_address[1:0] != 2'b11;

  // handshake into the queue
  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  // classification
  always_comb begin
    ent_o.bank = in_i.bank;
    ent_o.addr = in_i.reg_address;
    ent_o.data = dfix;
    ent_o.op   = OP_PASS;
    if (in_i.bank) begin
      if (in_i.reg_address == ADDR_KEYON) begin
        ent_o.bank = 1'b0;
        ent_o.data = (in_i.reg_data & KEYON_MASK) | KEYON_SET;
      end else if (fn_range) begin
        ent_o.op = in_i.reg_address[2] ? OP_FNUM_HI : OP_FNUM_LO;
      end
    end else begin
      priority if (in_i.reg_address == ADDR_MODE) begin
        ent_o.op   = OP_MODE;
        ent_o.data = in_i.reg_data;
      end else if (in_i.reg_address == ADDR_CSM) begin
        ent_o.op = OP_CSM;
      end else if (fn_range) begin
        ent_o.op = in_i.reg_address[2] ? OP_FNUM_HI : OP_FNUM_LO;
      end else if (in_i.reg_address < ADDR_NOISE) begin
        ent_o.op = OP_TONE;
      end else if (in_i.reg_address == ADDR_NOISE) begin
        ent_o.op = OP_NOISE;
      end else if (in_i.reg_address == ADDR_ENV_LO || in_i.reg_address == ADDR_ENV_HI) begin
        ent_o.op = OP_ENV;
      end else begin
        ent_o.op = OP_PASS;
      end
    end
  end

endmodule

// File: sv/fmrc_queue.sv
`timescale 1ns / 1ps
// short queue of classified items between front and back end
// depends on fmrc_pkg
module fmrc_queue import fmrc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  qent_t ent_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output qent_t ent_o
);

  localparam int unsigned PW = $clog2(QDEPTH);

  qent_t          mem_q [QDEPTH];
  logic [PW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]    cnt_q, cnt_d;

  assign full_o  = cnt_q == (PW + 1)'(QDEPTH);
  assign valid_o = cnt_q != '0;
  assign ent_o   = mem_q[rd_q];

  // pointer and count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= ent_i;
    end
  end

endmodule

// File: sv/fmrc_back.sv
`timescale 1ns / 1ps
// back end: shadow stores, rescaling arithmetic and result output register
// depends on fmrc_pkg, fmrc_if and assert_macros.svh
`include "assert_macros.svh"
module fmrc_back import fmrc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [2:0]  std_div_i,
  input  logic [2:0]  ext_div_i,
  input  logic        q_valid_i,
  input  qent_t       q_ent_i,
  output logic        q_pop_o,
  fmrc_out_if.source  out_o
);

  st_e         state_q, state_d;
  qent_t       ent_q, ent_d;
  logic        spm_q, spm_d;

  // shadow stores
  logic [7:0]            fmem [FNUM_DEPTH];
  logic [FNUM_DEPTH-1:0] fvld_q;
  logic [7:0]            frd0_q, frd1_q;
  logic                  fwe;
  logic [4:0]            fwa, fra0, fra1;
  logic [7:0]            pmem [PSG_DEPTH];
  logic [PSG_DEPTH-1:0]  pvld_q;
  logic [7:0]            prd0_q, prd1_q;
  logic                  pwe;
  logic [3:0]            pwa, pra0, pra1;
  logic [7:0]            pwd;

  // datapath registers
  logic [7:0]  lo_q, lo_d, hi_q, hi_d, cvl_q, cvl_d, cvh_q, cvh_d;
  logic [11:0] ff_q, ff_d;
  logic [28:0] prod_q, prod_d;
  logic [15:0] q_q, q_d;
  logic [21:0] x_q, x_d;
  logic [11:0] f_q, f_d;
  logic        sat_q, sat_d;

  // result list and output register
  wr_t         r0_q, r0_d, r1_q, r1_d;
  logic [1:0]  rcnt_q, rcnt_d, ridx_q, ridx_d;
  logic        out_vld_q;
  wr_t         out_q;
  logic        out_last_q;
  logic        slot_free, out_load, load_last;

  // shared decode
  logic [1:0]  p_std;
  logic [2:0]  div_sel, div_eff;
  logic [3:0]  base4;
  logic [11:0] tone_t;

  assign p_std   = eg_off(std_div_i);
  assign div_sel = ent_q.bank ? ext_div_i : std_div_i;
  assign div_eff = (div_sel == 3'd0) ? 3'd1 : div_sel;
  assign base4   = {ent_q.addr[3:1], 1'b0};
  assign tone_t  = (q_q > TONE_MAX) ? TONE_MAX[11:0] : q_q[11:0];

  assign slot_free = !out_vld_q || out_o.ready;
  assign out_load  = state_q == S_EMIT && ridx_q != rcnt_q && slot_free;
  assign load_last = ridx_q + 2'd1 == rcnt_q;
  assign q_pop_o   = state_q == S_IDLE && q_valid_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) state_d = S_WRITE;
      end
      S_WRITE: begin
        unique case (ent_q.op)
          OP_FNUM_HI:                  state_d = S_IDLE;
          OP_FNUM_LO, OP_TONE, OP_ENV: state_d = S_RD_RAW;
          OP_NOISE:                    state_d = S_M1;
          default:                     state_d = S_EMIT;
        endcase
      end
      S_RD_RAW:  state_d = S_RD_CONV;
      S_RD_CONV: state_d = S_M1;
      S_M1:      state_d = S_M2;
      S_M2:      state_d = S_M3;
      S_M3: begin
        state_d = (ent_q.op == OP_FNUM_LO || ent_q.op == OP_TONE) ? S_M4 : S_EMIT;
      end
      S_M4: begin
        state_d = (ent_q.op == OP_FNUM_LO) ? S_FIN : S_EMIT;
      end
      S_FIN: state_d = S_EMIT;
      S_EMIT: begin
        if (ridx_q == rcnt_q || (out_load && load_last)) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    logic [11:0] q0, rem, fn;
    logic [14:0] qd;
    logic [17:0] vw;
    logic [15:0] val;
    logic [35:0] p3;
    logic [44:0] p625;
    logic [7:0]  hb, lb;
    logic        hneq, lneq, big;
    wr_t         hw, lw;

    ent_d  = ent_q;
    spm_d  = spm_q;
    lo_d   = lo_q;
    hi_d   = hi_q;
    cvl_d  = cvl_q;
    cvh_d  = cvh_q;
    ff_d   = ff_q;
    prod_d = prod_q;
    q_d    = q_q;
    x_d    = x_q;
    f_d    = f_q;
    sat_d  = sat_q;
    r0_d   = r0_q;
    r1_d   = r1_q;
    rcnt_d = rcnt_q;
    ridx_d = ridx_q;

    fwe  = 1'b0;
    fwa  = {ent_q.bank, ent_q.addr[3:0]};
    fra0 = {ent_q.bank, ent_q.addr[3:0]};
    fra1 = {ent_q.bank, ent_q.addr[3], 1'b1, ent_q.addr[1:0]};
    pwe  = 1'b0;
    pwa  = ent_q.addr[3:0];
    pwd  = ent_q.data;
    if (state_q == S_RD_CONV) begin
      pra0 = base4 + PSG_CONV_OFS;
      pra1 = base4 + PSG_CONV_OFS + 4'd1;
    end else if (ent_q.op == OP_ENV) begin
      pra0 = PSG_ENV_LO;
      pra1 = PSG_ENV_HI;
    end else begin
      pra0 = base4;
      pra1 = base4 + 4'd1;
    end

    q0   = prod_q[27:16];
    qd   = {3'b0, q0} * {12'b0, div_eff};
    rem  = ff_q - qd[11:0];
    val  = '0;
    vw   = '0;
    p3   = {18'b0, prod_q[25:8]} * RECIP_3;
    p625 = {23'b0, x_q} * RECIP_625;
    hb   = {4'b0, tone_t[11:8]};
    lb   = tone_t[7:0];
    hneq = cvh_q != hb;
    lneq = cvl_q != lb;
    hw   = '{bank: 1'b0, addr: {4'b0, base4 + 4'd1}, data: hb};
    lw   = '{bank: 1'b0, addr: {4'b0, base4}, data: lb};
    big  = f_q[11];
    fn   = big ? {1'b0, f_q[11:1]} : f_q;

    unique case (state_q)
      S_IDLE: begin
        ridx_d = '0;
        if (q_valid_i) ent_d = q_ent_i;
      end
      S_WRITE: begin
        rcnt_d = 2'd1;
        r0_d   = '{bank: ent_q.bank, addr: ent_q.addr, data: ent_q.data};
        unique case (ent_q.op)
          OP_MODE: begin
            spm_d     = ent_q.data[7];
            r0_d.data = (ent_q.data[7:6] == 2'b00) ? 8'h00 : MODE_ON;
          end
          OP_CSM: begin
            r0_d   = '{bank: 1'b0, addr: ADDR_KEYON, data: CSM_KEY_OFF};
            r1_d   = '{bank: 1'b0, addr: ADDR_KEYON, data: CSM_KEY_ON};
            rcnt_d = spm_q ? 2'd2 : 2'd0;
          end
          OP_FNUM_HI, OP_FNUM_LO: fwe = 1'b1;
          OP_TONE:                pwe = 1'b1;
          OP_ENV: begin
            pwe = 1'b1;
            pwa = ent_q.addr[3:0] - PSG_ENV_OFS;
          end
          default: ;
        endcase
      end
      S_RD_RAW: ;
      S_RD_CONV: begin
        lo_d = (ent_q.op == OP_FNUM_LO) ? frd0_q : prd0_q;
        hi_d = (ent_q.op == OP_FNUM_LO) ? frd1_q : prd1_q;
      end
      S_M1: begin
        // first product: F times divider reciprocal, or value times 625
        cvl_d = prd0_q;
        cvh_d = prd1_q;
        ff_d  = {hi_q[2:0], lo_q, 1'b0};
        unique case (ent_q.op)
          OP_TONE: val = {4'b0, hi_q[3:0], lo_q};
          OP_ENV:  val = {hi_q, lo_q};
          default: val = {11'b0, ent_q.data[4:0]};
        endcase
        vw    = {2'b0, val} << p_std;
        sat_d = vw >= ENV_SAT_LIM;
        if (ent_q.op == OP_FNUM_LO) begin
          prod_d = {17'b0, hi_q[2:0], lo_q, 1'b0} * {12'b0, recip_div(div_sel)};
        end else begin
          prod_d = {11'b0, vw} * PSG_MUL;
        end
      end
      S_M2: begin
        // quotient with one correction step, or divide by 768
        if (ent_q.op == OP_FNUM_LO) begin
          q_d = {4'b0, (rem >= {9'b0, div_eff}) ? q0 + 12'd1 : q0};
        end else begin
          q_d = p3[34:19];
        end
      end
      S_M3: begin
        x_d = {10'b0, q_q[11:0]} * FN_MUL;
        unique case (ent_q.op)
          OP_TONE: begin
            pwe    = 1'b1;
            pwa    = base4 + PSG_CONV_OFS + 4'd1;
            pwd    = hb;
            r0_d   = hneq ? hw : lw;
            r1_d   = lw;
            rcnt_d = {1'b0, hneq} + {1'b0, lneq};
          end
          OP_NOISE: begin
            r0_d   = '{bank: 1'b0, addr: ADDR_NOISE,
                       data: (q_q > NOISE_MAX) ? NOISE_MAX[7:0] : q_q[7:0]};
            rcnt_d = 2'd1;
          end
          OP_ENV: begin
            r0_d   = '{bank: 1'b0, addr: ADDR_ENV_HI,
                       data: sat_q ? ENV_SAT_VAL[15:8] : q_q[15:8]};
            r1_d   = '{bank: 1'b0, addr: ADDR_ENV_LO,
                       data: sat_q ? ENV_SAT_VAL[7:0] : q_q[7:0]};
            rcnt_d = 2'd2;
          end
          default: ;
        endcase
      end
      S_M4: begin
        f_d = p625[43:32];
        if (ent_q.op == OP_TONE) begin
          pwe = 1'b1;
          pwa = base4 + PSG_CONV_OFS;
          pwd = lb;
        end
      end
      S_FIN: begin
        // block count and f-number result pair
        r0_d   = '{bank: ent_q.bank, addr: ent_q.addr + 8'd4,
                   data: {4'b0, big, fn[10:8]} + (hi_q & FN_BLK_MASK)};
        r1_d   = '{bank: ent_q.bank, addr: ent_q.addr, data: fn[7:0]};
        rcnt_d = 2'd2;
      end
      S_EMIT: begin
        if (out_load) ridx_d = ridx_q + 2'd1;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      spm_q     <= 1'b0;
      rcnt_q    <= '0;
      ridx_q    <= '0;
      out_vld_q <= 1'b0;
      fvld_q    <= '0;
      pvld_q    <= '0;
    end else begin
      state_q <= state_d;
      spm_q   <= spm_d;
      rcnt_q  <= rcnt_d;
      ridx_q  <= ridx_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (fwe) fvld_q[fwa] <= 1'b1;
      if (pwe) pvld_q[pwa] <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ent_q  <= ent_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    cvl_q  <= cvl_d;
    cvh_q  <= cvh_d;
    ff_q   <= ff_d;
    prod_q <= prod_d;
    q_q    <= q_d;
    x_q    <= x_d;
    f_q    <= f_d;
    sat_q  <= sat_d;
    r0_q   <= r0_d;
    r1_q   <= r1_d;
    if (out_load) begin
      out_q      <= ridx_q[0] ? r1_q : r0_q;
      out_last_q <= load_last;
    end
  end

  // f-number shadow memory, unwritten entries read as zero
  always_ff @(posedge clk_i) begin
    if (fwe) fmem[fwa] <= ent_q.data;
    frd0_q <= fvld_q[fra0] ? fmem[fra0] : FNUM_RESET;
    frd1_q <= fvld_q[fra1] ? fmem[fra1] : FNUM_RESET;
  end

  // psg shadow memory, unwritten entries read as all ones
  always_ff @(posedge clk_i) begin
    if (pwe) pmem[pwa] <= pwd;
    prd0_q <= pvld_q[pra0] ? pmem[pra0] : PSG_RESET;
    prd1_q <= pvld_q[pra1] ? pmem[pra1] : PSG_RESET;
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.out_bank    = out_q.bank;
  assign out_o.out_address = out_q.addr;
  assign out_o.out_data    = out_q.data;
  assign out_o.last        = out_last_q;

  `FMRC_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> (state_q == S_IDLE && !out_vld_q), "not idle in reset")
  `FMRC_ASSERT(a_emit_index, state_q == S_EMIT |-> (ridx_q < rcnt_q || rcnt_q == 2'd0), "result index past count")
  `FMRC_ASSERT(a_tone_to_emit, (state_q == S_M4 && ent_q.op == OP_TONE) |=> state_q == S_EMIT, "tone path misrouted")
  `FMRC_ASSERT(a_fnum_hi_silent, (state_q == S_WRITE && ent_q.op == OP_FNUM_HI) |=> state_q == S_IDLE, "upper f-number byte produced work")

endmodule
